>>> rtl/core/mpdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdf_pkg
// Shared widths, command/status structs and the constant prime table.
// ----------------------------------------------------------------------------
package mpdf_pkg;

    localparam int unsigned DATA_W  = 10;
    localparam int unsigned ACC_W   = 11;
    localparam int unsigned LIMIT   = 1 << DATA_W;

    typedef struct packed {
        logic load;
        logic cand_step;
        logic div_start;
        logic div_sel_leg;
        logic strip_take;
        logic leg_take;
        logic ea_clear;
        logic fold;
        logic q_start;
        logic q_take;
    } mpdf_cmd_t;

    typedef struct packed {
        logic r_le1;
        logic cand_gt_r;
        logic cand_prime;
        logic div_done;
        logic rem_zero;
        logic quot_zero;
        logic ea_zero;
    } mpdf_sts_t;

    function automatic logic [LIMIT-1:0] build_prime_mask();
        logic [LIMIT-1:0] m;
        m    = '1;
        m[0] = 1'b0;
        m[1] = 1'b0;
        for (int i = 2; i * i < int'(LIMIT); i++)
        begin
            if (m[i])
            begin
                for (int j = i * i; j < int'(LIMIT); j += i)
                begin
                    m[j] = 1'b0;
                end
            end
        end
        return m;
    endfunction

    // prime flag for every DATA_W-bit candidate
    localparam logic [LIMIT-1:0] PRIME_MASK = build_prime_mask();

endpackage
`default_nettype wire

>>> rtl/core/max_power_dividing_factorial.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_power_dividing_factorial
// Largest k with a^k dividing n!, by Legendre's formula over prime factors.
//
// channel  dir  tdata                              tuser
// s_axis   in   [9:0] n, [19:10] a                 -
// m_axis   out  [9:0] max_power                    [0] valid_res
//
// One transaction at a time. The candidate walk steps past each composite;
// each prime candidate is trial-divided into the cofactor by the 11-step
// serial divider, which also serves each strip step, each Legendre term
// and the final quotient.
// Reset returns the controller to idle; no clearing pass.
// s_axis_tready is low from acceptance until the result is taken.
// ----------------------------------------------------------------------------
module max_power_dividing_factorial
    import mpdf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // n, a
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // max_power
    output logic             m_axis_tuser    // valid_res
);

    mpdf_cmd_t         cmd;
    mpdf_sts_t         sts;
    logic [DATA_W-1:0] best;
    logic              found;
    logic              in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    mpdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    mpdf_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .n     (s_axis_tdata[9:0]),
        .a     (s_axis_tdata[19:10]),
        .cmd   (cmd),
        .sts   (sts),
        .best  (best),
        .found (found)
    );

    assign m_axis_tdata = {6'd0, best};
    assign m_axis_tuser = found;

endmodule
`default_nettype wire

>>> rtl/core/mpdf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpdf_div
    import mpdf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACC_W-1:0]  dividend,
    input  wire logic [ACC_W-1:0]  divisor,
    output logic                   done,
    output logic [ACC_W-1:0]       quot,
    output logic [ACC_W-1:0]       rem
);

    localparam int unsigned CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] q_reg, q_next;
    logic [ACC_W-1:0] r_reg, r_next;
    logic [ACC_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [ACC_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[ACC_W-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CNT_W'(ACC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = ACC_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[ACC_W-1:0];
                q_next = {q_reg[ACC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done = !busy_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule
`default_nettype wire

>>> rtl/core/mpdf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdf_datapath
// Candidate counter, cofactor, Legendre sum and running minimum.
// ----------------------------------------------------------------------------
module mpdf_datapath
    import mpdf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [DATA_W-1:0] n,
    input  wire logic [DATA_W-1:0] a,
    input  wire mpdf_cmd_t         cmd,
    output mpdf_sts_t              sts,
    output logic [DATA_W-1:0]      best,
    output logic                   found
);

    logic [ACC_W-1:0] n_reg, r_reg, p_reg, t_reg, sum_reg, ea_reg, best_reg;
    logic             found_reg;
    logic [ACC_W-1:0] dvd, dvs, quot, rem;
    logic             div_done;

    always_comb
    begin
        dvd = r_reg;
        dvs = p_reg;
        if (cmd.div_sel_leg)
        begin
            dvd = t_reg;
        end
        if (cmd.q_start)
        begin
            dvd = sum_reg;
            dvs = ea_reg;
        end
    end

    mpdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.q_take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= {1'b0, n};
            r_reg <= {1'b0, a};
            p_reg <= ACC_W'(2);
        end
        if (cmd.cand_step)
        begin
            p_reg <= p_reg + 1'b1;
        end
        if (cmd.ea_clear)
        begin
            ea_reg  <= '0;
            t_reg   <= n_reg;
            sum_reg <= '0;
        end
        if (cmd.strip_take)
        begin
            r_reg  <= quot;
            ea_reg <= ea_reg + 1'b1;
        end
        if (cmd.leg_take)
        begin
            t_reg   <= quot;
            sum_reg <= sum_reg + quot;
        end
        if (cmd.q_take)
        begin
            if (!found_reg || quot < best_reg)
            begin
                best_reg <= quot;
            end
        end
    end

    assign sts.r_le1      = (r_reg <= ACC_W'(1));
    assign sts.cand_gt_r  = (p_reg > r_reg);
    assign sts.cand_prime = PRIME_MASK[p_reg[DATA_W-1:0]];
    assign sts.div_done   = div_done;
    assign sts.rem_zero   = (rem == '0);
    assign sts.quot_zero  = (quot == '0);
    assign sts.ea_zero    = (ea_reg == '0);
    assign best  = found_reg ? best_reg[DATA_W-1:0] : '0;
    assign found = found_reg;

endmodule
`default_nettype wire

>>> rtl/core/mpdf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdf_ctrl
// Sequencer: walk candidates, strip each prime, sum Legendre terms, fold.
// ----------------------------------------------------------------------------
module mpdf_ctrl
    import mpdf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic out_fire,
    input  wire mpdf_sts_t sts,
    output mpdf_cmd_t cmd,
    output logic      in_ready,
    output logic      out_valid
);

    typedef enum logic [3:0] {
        S_IDLE, S_CAND, S_STRIP, S_STRIP_W, S_LEG, S_LEG_W, S_Q_W, S_NEXT, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                if (sts.r_le1 || sts.cand_gt_r)
                begin
                    state_next = S_OUT;
                end
                else if (!sts.cand_prime)
                begin
                    cmd.cand_step = 1'b1;
                end
                else
                begin
                    cmd.ea_clear = 1'b1;
                    state_next   = S_STRIP;
                end
            end
            S_STRIP:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_STRIP_W;
            end
            S_STRIP_W:
            begin
                if (sts.div_done)
                begin
                    if (sts.rem_zero)
                    begin
                        cmd.strip_take = 1'b1;
                        state_next     = S_STRIP;
                    end
                    else if (sts.ea_zero)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        state_next = S_LEG;
                    end
                end
            end
            S_LEG:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_leg = 1'b1;
                state_next      = S_LEG_W;
            end
            S_LEG_W:
            begin
                if (sts.div_done)
                begin
                    cmd.leg_take = 1'b1;
                    if (sts.quot_zero)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.q_start   = 1'b1;
                        state_next    = S_Q_W;
                    end
                    else
                    begin
                        state_next = S_LEG;
                    end
                end
            end
            S_Q_W:
            begin
                if (sts.div_done)
                begin
                    cmd.q_take = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.cand_step = 1'b1;
                state_next    = S_CAND;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule
`default_nettype wire

>>> rtl/core/mpdf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdf_sva
// Port-level checks on the input handshake and the result stream.
// ----------------------------------------------------------------------------
module mpdf_sva (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result in cycle after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("nonzero power on invalid result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

endmodule

bind max_power_dividing_factorial mpdf_sva u_mpdf_sva (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
